[rtl/core/rbm_pkg.sv]
// shared types, register addresses and helpers for the rom bank mapper
package rbm_pkg;

    localparam int unsigned BANK_REG_BITS_DEF = 8;

    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned OFFSET_W   = 21;
    localparam int unsigned LOG2_W     = 4;
    localparam int unsigned MASK_W     = 8;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned PRG_PAGE_W = 13;
    localparam int unsigned CHR_PAGE_W = 10;
    localparam int unsigned PRG_WINDOWS = 3;
    localparam int unsigned CHR_WINDOWS = 8;

    localparam logic [LOG2_W-1:0] LOG2_MAX       = 4'd8;
    localparam logic [LOG2_W-1:0] PRG_LOG2_RESET = 4'd4;
    localparam logic [LOG2_W-1:0] CHR_LOG2_RESET = 4'd7;
    localparam logic [DATA_W-1:0] PRG_BANK1_RESET = 8'h01;
    localparam logic [DATA_W-1:0] PRG_BANK2_RESET = 8'hFE;

    // exact bus addresses of the mapper registers
    localparam logic [ADDR_W-1:0] ADDR_PRG0       = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_PRG1       = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_PRG2       = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_MIRROR     = 16'h9001;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE = 16'h9003;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_RELOAD = 16'h9004;
    localparam logic [ADDR_W-1:0] ADDR_RELOAD_HI  = 16'h9005;
    localparam logic [ADDR_W-1:0] ADDR_RELOAD_LO  = 16'h9006;
    localparam logic [ADDR_W-1:0] ADDR_CHR_FIRST  = 16'hB000;
    localparam logic [ADDR_W-1:0] ADDR_CHR_LAST   = 16'hB007;
    localparam logic [ADDR_W-1:0] ADDR_PRG_BASE   = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_CHR_END    = 16'h2000;

    localparam int unsigned FLAG_BIT = 7;

    // configuration register indexes
    localparam logic [0:0] CFG_PRG_LOG2 = 1'b0;
    localparam logic [0:0] CFG_CHR_LOG2 = 1'b1;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_PRG   = 2'd2,
        REQ_CHR   = 2'd3
    } req_type_t;

    // power-of-two bank mask, log2 saturated at eight
    function automatic logic [MASK_W-1:0] size_mask(input logic [LOG2_W-1:0] lg);
        logic [MASK_W:0] full;
        full = (lg >= LOG2_MAX) ? {1'b1, {MASK_W{1'b0}}}
                                : ((MASK_W+1)'(1) << lg[LOG2_W-2:0]);
        return MASK_W'(full - (MASK_W+1)'(1));
    endfunction

endpackage

[rtl/core/rom_bank_mapper_with_irq_timer_unit.sv]
// top level of the rom bank mapper with tick-driven irq counter
// an accepted input beat has its result beat in the output register in the next cycle
// throughput: one beat per cycle while m_tready is high, set by the single register stage between decode and output
// s_tready stays high while the output register is empty or being drained this cycle
// reset (aresetn low, synchronous): bank, mirroring and irq state and both log2 registers
// return to their defaults, the output register is emptied; no clearing pass is needed
module rom_bank_mapper_with_irq_timer_unit #(
    parameter int unsigned BANK_REG_BITS = rbm_pkg::BANK_REG_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // irq[0], rom_offset[21:1], mapped[22], mirror_horizontal[23]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbm_pkg::*;

    // configuration registers
    logic [LOG2_W-1:0] prg_log2_reg;
    logic [LOG2_W-1:0] chr_log2_reg;

    // mapper state
    logic [BANK_REG_BITS-1:0] prg_bank_reg [PRG_WINDOWS];
    logic [BANK_REG_BITS-1:0] chr_bank_reg [CHR_WINDOWS];
    logic                     mirror_reg;
    logic [COUNT_W-1:0]       irq_count_reg;
    logic [COUNT_W-1:0]       irq_reload_reg;
    logic                     irq_enabled_reg;
    logic                     irq_pending_reg;

    logic                     mirror_next;
    logic [COUNT_W-1:0]       irq_count_next;
    logic [COUNT_W-1:0]       irq_reload_next;
    logic                     irq_enabled_next;
    logic                     irq_pending_next;

    // output register
    logic                     out_valid_reg;
    logic [23:0]              out_data_reg;

    // unpacked input beat
    req_type_t            in_type;
    logic [ADDR_W-1:0]    in_addr;
    logic [DATA_W-1:0]    in_data;
    logic                 in_accept;
    logic                 cfg_write;
    logic [0:0]           cfg_idx;

    // translation path
    logic [MASK_W-1:0]    prg_bank_sel;
    logic [MASK_W-1:0]    chr_bank_sel;
    logic [OFFSET_W-1:0]  offset;
    logic                 hit;
    logic [COUNT_W-1:0]   count_dec;

    assign in_type   = req_type_t'(s_tuser);
    assign in_addr   = s_tdata[ADDR_W-1:0];
    assign in_data   = s_tdata[ADDR_W +: DATA_W];

    // output register parts the two sides: accept while empty or draining
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // apb: always ready, one bit of word address selects the register
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[2:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            CFG_PRG_LOG2: prdata = {{(32-LOG2_W){1'b0}}, prg_log2_reg};
            CFG_CHR_LOG2: prdata = {{(32-LOG2_W){1'b0}}, chr_log2_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_log2_reg <= PRG_LOG2_RESET;
            chr_log2_reg <= CHR_LOG2_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                CFG_PRG_LOG2: prg_log2_reg <= pwdata[LOG2_W-1:0];
                CFG_CHR_LOG2: chr_log2_reg <= pwdata[LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    // program window: the top window is pinned to the last bank
    always_comb begin
        case (in_addr[PRG_PAGE_W +: 2])
            2'd0:    prg_bank_sel = MASK_W'(prg_bank_reg[0]) & size_mask(prg_log2_reg);
            2'd1:    prg_bank_sel = MASK_W'(prg_bank_reg[1]) & size_mask(prg_log2_reg);
            2'd2:    prg_bank_sel = MASK_W'(prg_bank_reg[2]) & size_mask(prg_log2_reg);
            default: prg_bank_sel = size_mask(prg_log2_reg);
        endcase
    end

    assign chr_bank_sel = MASK_W'(chr_bank_reg[in_addr[CHR_PAGE_W +: 3]])
                          & size_mask(chr_log2_reg);

    assign count_dec = irq_count_reg - COUNT_W'(1);

    // next state and result for the beat at the input
    always_comb begin
        mirror_next      = mirror_reg;
        irq_count_next   = irq_count_reg;
        irq_reload_next  = irq_reload_reg;
        irq_enabled_next = irq_enabled_reg;
        irq_pending_next = irq_pending_reg;
        offset           = '0;
        hit              = 1'b0;

        unique case (in_type)
            REQ_WRITE: begin
                unique case (in_addr) inside
                    ADDR_MIRROR: mirror_next = in_data[FLAG_BIT];
                    ADDR_IRQ_ENABLE: begin
                        irq_enabled_next = in_data[FLAG_BIT];
                        irq_pending_next = 1'b0;
                    end
                    ADDR_IRQ_RELOAD: begin
                        irq_count_next   = irq_reload_reg;
                        irq_pending_next = 1'b0;
                    end
                    ADDR_RELOAD_HI: irq_reload_next = {in_data, irq_reload_reg[7:0]};
                    ADDR_RELOAD_LO: irq_reload_next = {irq_reload_reg[15:8], in_data};
                    default: ;
                endcase
            end
            REQ_TICK: begin
                // a running counter decrements; reaching zero raises the irq
                if (irq_enabled_reg && (irq_count_reg != '0)) begin
                    irq_count_next = count_dec;
                    if (count_dec == '0) begin
                        irq_pending_next = 1'b1;
                    end
                end
            end
            REQ_PRG: begin
                if (in_addr >= ADDR_PRG_BASE) begin
                    offset = {prg_bank_sel, in_addr[PRG_PAGE_W-1:0]};
                    hit    = 1'b1;
                end
            end
            REQ_CHR: begin
                if (in_addr < ADDR_CHR_END) begin
                    offset = OFFSET_W'({chr_bank_sel, in_addr[CHR_PAGE_W-1:0]});
                    hit    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // bank registers keep only the low bank bits of the written byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_bank_reg[0] <= '0;
            prg_bank_reg[1] <= BANK_REG_BITS'(PRG_BANK1_RESET);
            prg_bank_reg[2] <= BANK_REG_BITS'(PRG_BANK2_RESET);
            for (int i = 0; i < CHR_WINDOWS; i++) begin
                chr_bank_reg[i] <= '0;
            end
        end else if (in_accept && (in_type == REQ_WRITE)) begin
            unique case (in_addr) inside
                ADDR_PRG0: prg_bank_reg[0] <= in_data[BANK_REG_BITS-1:0];
                ADDR_PRG1: prg_bank_reg[1] <= in_data[BANK_REG_BITS-1:0];
                ADDR_PRG2: prg_bank_reg[2] <= in_data[BANK_REG_BITS-1:0];
                [ADDR_CHR_FIRST:ADDR_CHR_LAST]:
                    chr_bank_reg[in_addr[2:0]] <= in_data[BANK_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_reg      <= 1'b0;
            irq_count_reg   <= '0;
            irq_reload_reg  <= '0;
            irq_enabled_reg <= 1'b0;
            irq_pending_reg <= 1'b0;
        end else if (in_accept) begin
            mirror_reg      <= mirror_next;
            irq_count_reg   <= irq_count_next;
            irq_reload_reg  <= irq_reload_next;
            irq_enabled_reg <= irq_enabled_next;
            irq_pending_reg <= irq_pending_next;
        end
    end

    // result register: state as left by the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_data_reg <= {mirror_next, hit, offset, irq_pending_next};
        end
    end

    // irq can only be raised by a tick
    a_irq_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(irq_pending_reg) |-> $past(in_accept && (in_type == REQ_TICK)))
        else $error("irq raised without a tick");

    // acknowledge clears the pending irq
    a_irq_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (in_type == REQ_WRITE)
         && ((in_addr == ADDR_IRQ_ENABLE) || (in_addr == ADDR_IRQ_RELOAD)))
        |=> !irq_pending_reg)
        else $error("irq acknowledge did not clear pending");

    // an idle counter does not move on a tick
    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (in_type == REQ_TICK)
         && (!irq_enabled_reg || (irq_count_reg == '0)))
        |=> $stable(irq_count_reg))
        else $error("stopped counter changed on tick");

    // unmapped results carry a zero offset
    a_unmapped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_data_reg[22]) |-> (out_data_reg[21:1] == '0))
        else $error("unmapped result with nonzero offset");

endmodule
